[rtl/core/tmlr_pkg.sv]
// shared constants, payload types and helpers of the text mode line renderer
`timescale 1ns / 1ps
`default_nettype none

package tmlr_pkg;

   // geometry
   localparam int TEXT_COLS    = 80;
   localparam int TEXT_ROWS    = 30;
   localparam int GLYPH_HEIGHT = 16;
   localparam int ICON_WIDTH   = 128;
   localparam int BG_DEPTH     = 256;

   localparam int ICON_ROW_BYTES  = (ICON_WIDTH + 7) / 8;
   localparam int ICON_BYTES      = ICON_ROW_BYTES * ICON_WIDTH;
   localparam int ICON_BANK_DEPTH = ICON_BYTES / 2;
   localparam int ICON_WORDS      = ICON_WIDTH / 2;
   localparam int CELL_COUNT      = TEXT_ROWS * TEXT_COLS;
   localparam int GLYPH_COUNT     = 256 * GLYPH_HEIGHT;

   // address widths
   localparam int CELL_AW      = $clog2(CELL_COUNT);
   localparam int GLYPH_AW     = $clog2(GLYPH_COUNT);
   localparam int GLYPH_LW     = $clog2(GLYPH_HEIGHT);
   localparam int ICON_AW      = $clog2(ICON_BYTES);
   localparam int ICON_BANK_AW = ICON_AW - 1;
   localparam int ICON_ROW_W   = $clog2(ICON_WIDTH);
   localparam int BG_AW        = $clog2(BG_DEPTH);
   localparam int WIDX_W0      = (GLYPH_AW > ICON_AW) ? GLYPH_AW : ICON_AW;
   localparam int WIDX_W       = (WIDX_W0 > BG_AW) ? WIDX_W0 : BG_AW;

   // signed word offset of a column against the icon edge
   localparam int OFF_W = 12;

   // power-up clearing sweep
   localparam int CLR_COUNT = (CELL_COUNT > ICON_BANK_DEPTH) ? CELL_COUNT : ICON_BANK_DEPTH;
   localparam int CLR_W     = $clog2(CLR_COUNT);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_AW = 3;
   localparam int CFG_W  = 10;
   localparam logic [CFG_W-1:0] ICON_LEFT_RESET = 10'd400;
   localparam logic [CFG_W-1:0] ICON_TOP_RESET  = 10'd1023;
   localparam logic [7:0]       ICON_RESET_BYTE = 8'h55;
   localparam logic [7:0]       CELL_RESET_BYTE = 8'h00;

   typedef enum logic {
      REG_ICON_LEFT = 1'b0,
      REG_ICON_TOP  = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      KIND_CELL   = 3'd0,
      KIND_GLYPH  = 3'd1,
      KIND_ICON   = 3'd2,
      KIND_COLOUR = 3'd3,
      KIND_RENDER = 3'd4
   } req_kind_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [10:0] addr;
      logic [6:0]  column;
      logic [7:0]  char_code;
      logic [15:0] value;
      logic [8:0]  line;
      logic [7:0]  frame;
   } req_item_type;

   typedef struct packed {
      logic [6:0]  out_column;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] icon_left;
      logic [CFG_W-1:0] icon_top;
   } icon_cfg_type;

   // per output word: icon covers it, takes the second fetched byte, pair slot
   typedef struct packed {
      logic       on;
      logic       hi;
      logic [1:0] pair;
   } icon_word_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [CELL_AW-1:0]     cell_idx;
      logic [WIDX_W-1:0]      widx;
      logic [15:0]            wdata;
      logic [6:0]             column;
      logic [GLYPH_LW-1:0]    glyph_line;
      logic                   row_ok;
      logic [BG_AW-1:0]       colour_idx;
      logic [ICON_AW-1:0]     icon_b0;
      icon_word_type [3:0]    icon_word;
   } op_entry_type;

   function automatic logic [31:0] pair_word(input logic [1:0] pair,
                                             input logic [15:0] colour);
      logic [31:0] word;
      case (pair)
         2'b01:   word = {colour, 16'h0000};
         2'b10:   word = {16'h0000, colour};
         2'b11:   word = {colour, colour};
         default: word = 32'h0;
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

[rtl/core/text_mode_line_renderer.sv]
// top level of the text mode line renderer with icon overlay
//
//  channel    direction  transfer marker            payload
//  request    in         start & !busy              req_data (req_item_type)
//  result     out        rsp_valid, one cycle       rsp_data (rsp_item_type)
//  registers  in/out     psel & penable & pwrite    paddr, pwdata, prdata
//
// one request per cycle while busy is low; a render result passes the queue,
// the cell/colour/icon read, the glyph read and pixel pairing + output reg
// the glyph read depends on the fetched character, which sets the pipe depth
// after reset busy stays high while the grid and icon sweep
// the receiver cannot stall; busy only covers the sweep and a full queue
`timescale 1ns / 1ps
`default_nettype none

module text_mode_line_renderer import tmlr_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              start,
   output logic                   busy,
   input  wire req_item_type      req_data,
   // result channel
   output logic                   rsp_valid,
   output rsp_item_type           rsp_data,
   // register port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   logic [CFG_W-1:0] icon_left_ff, icon_left_in;
   logic [CFG_W-1:0] icon_top_ff, icon_top_in;
   icon_cfg_type     cfg;
   logic             csr_wr;
   csr_reg_type      csr_sel;

   logic         take;
   logic         push;
   op_entry_type push_entry;
   op_entry_type head;
   logic         head_valid;
   logic         q_full;
   logic         pop;
   logic         clearing;

   // register file: index taken from the word address
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = csr_reg_type'(paddr[2]);

   always_comb begin
      icon_left_in = icon_left_ff;
      icon_top_in  = icon_top_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_ICON_LEFT: icon_left_in = pwdata[CFG_W-1:0];
            REG_ICON_TOP:  icon_top_in  = pwdata[CFG_W-1:0];
            default:       icon_left_in = icon_left_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         REG_ICON_LEFT: prdata = 32'(icon_left_ff);
         REG_ICON_TOP:  prdata = 32'(icon_top_ff);
         default:       prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         icon_left_ff <= ICON_LEFT_RESET;
         icon_top_ff  <= ICON_TOP_RESET;
      end else begin
         icon_left_ff <= icon_left_in;
         icon_top_ff  <= icon_top_in;
      end
   end

   assign cfg.icon_left = icon_left_ff;
   assign cfg.icon_top  = icon_top_ff;

   // request transfer: refused during the sweep or with the queue full
   assign busy = clearing || q_full;
   assign take = start && !busy;

   // front end classifies and drops out-of-range requests
   tmlr_front u_front (
      .take  (take),
      .req   (req_data),
      .cfg   (cfg),
      .push  (push),
      .entry (push_entry)
   );

   tmlr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // back end owns the tables and the render pipe
   tmlr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/tmlr_ram.sv]
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tmlr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/tmlr_front.sv]
// front end: range checks, classification and address precompute per request
`timescale 1ns / 1ps
`default_nettype none

module tmlr_front import tmlr_pkg::*; (
   input  wire logic         take,
   input  wire req_item_type req,
   input  wire icon_cfg_type cfg,
   output logic              push,
   output op_entry_type      entry
);

   logic                   ok;
   logic [8:0]             row_full;
   logic                   row_ok;
   logic [11:0]            cell_row;
   logic [11:0]            line_ext;
   logic [11:0]            top_ext;
   logic [11:0]            top_end;
   logic                   icon_on;
   logic [ICON_ROW_W-1:0]  icon_row;
   logic signed [OFF_W-1:0] start_off;
   logic signed [OFF_W-1:0] off [4];
   logic [OFF_W-3:0]       base;

   always_comb begin
      case (req.req_type)
         KIND_CELL:   ok = (req.addr < TEXT_ROWS) && (req.column < TEXT_COLS);
         KIND_GLYPH:  ok = req.addr < GLYPH_HEIGHT;
         KIND_ICON:   ok = req.addr < ICON_BYTES;
         KIND_COLOUR: ok = req.addr < BG_DEPTH;
         KIND_RENDER: ok = req.column < TEXT_COLS;
         default:     ok = 1'b0;
      endcase
   end

   assign push = take && ok;

   // text row of the scan line; lines below the grid show no glyph bits
   assign row_full = req.line / 9'(GLYPH_HEIGHT);
   assign row_ok   = row_full < TEXT_ROWS;

   always_comb begin
      if (req.req_type == KIND_CELL) begin
         cell_row = 12'(req.addr);
      end else if (row_ok) begin
         cell_row = 12'(row_full);
      end else begin
         cell_row = 12'd0;
      end
   end

   // icon vertical window, top line itself excluded
   assign line_ext = 12'(req.line);
   assign top_ext  = 12'(cfg.icon_top);
   assign top_end  = top_ext + 12'(ICON_WIDTH);
   assign icon_on  = (line_ext > top_ext) && (line_ext < top_end);
   assign icon_row = ICON_ROW_W'(line_ext - top_ext);

   // word offset of this column's first word against the icon's left edge
   assign start_off = $signed(OFF_W'({req.column, 2'b00})) -
                      $signed(OFF_W'(cfg.icon_left[CFG_W-1:1]));
   assign base = start_off[OFF_W-1] ? '0 : start_off[OFF_W-1:2];

   always_comb begin
      entry            = '0;
      entry.kind       = req_kind_type'(req.req_type);
      entry.cell_idx   = CELL_AW'(int'(cell_row) * TEXT_COLS + int'(req.column));
      entry.wdata      = req.value;
      entry.column     = req.column;
      entry.glyph_line = GLYPH_LW'(req.line % 9'(GLYPH_HEIGHT));
      entry.row_ok     = row_ok;
      entry.colour_idx = BG_AW'(req.frame + req.line[7:0]);
      entry.icon_b0    = ICON_AW'(int'(icon_row) * ICON_ROW_BYTES + int'(base));
      case (req.req_type)
         KIND_GLYPH: entry.widx = WIDX_W'(int'(req.char_code) * GLYPH_HEIGHT +
                                          int'(req.addr));
         // a cell stores the character code
         KIND_CELL: begin
            entry.widx  = WIDX_W'(req.addr);
            entry.wdata = 16'(req.char_code);
         end
         default:    entry.widx = WIDX_W'(req.addr);
      endcase
      for (int k = 0; k < 4; k++) begin
         off[k] = start_off + OFF_W'(k);
         entry.icon_word[k].on   = icon_on && !off[k][OFF_W-1] &&
                                   (off[k][OFF_W-2:0] < (OFF_W-1)'(ICON_WORDS));
         entry.icon_word[k].hi   = off[k][OFF_W-1:2] != base;
         entry.icon_word[k].pair = off[k][1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/core/tmlr_queue.sv]
// short command queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module tmlr_queue import tmlr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire op_entry_type push_entry,
   input  wire logic         pop,
   output op_entry_type      head,
   output logic              head_valid,
   output logic              full
);

   op_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign head_valid = count_ff != '0;
   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[rtl/core/tmlr_back.sv]
// back end: table writes, clearing sweep and the three-stage render pipe
`timescale 1ns / 1ps
`default_nettype none

module tmlr_back import tmlr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire op_entry_type head,
   input  wire logic         head_valid,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   output rsp_item_type      rsp_data
);

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } back_state_type;

   typedef struct packed {
      logic [6:0]          column;
      logic [GLYPH_LW-1:0] glyph_line;
      logic                row_ok;
      logic                first_odd;
      icon_word_type [3:0] icon_word;
   } stage_meta_type;

   typedef struct packed {
      stage_meta_type meta;
      logic [15:0]    colour;
      logic [7:0]     icon_even;
      logic [7:0]     icon_odd;
   } stage2_type;

   back_state_type state_ff, state_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic                    render;
   logic                    clr_cell;
   logic                    clr_icon;
   logic                    cell_we;
   logic [CELL_AW-1:0]      cell_wa;
   logic [7:0]              cell_wd;
   logic [7:0]              cell_rd;
   logic                    even_we, odd_we;
   logic [ICON_BANK_AW-1:0] even_wa, odd_wa;
   logic [ICON_BANK_AW-1:0] even_ra, odd_ra;
   logic [7:0]              icon_wd;
   logic [7:0]              even_rd, odd_rd;
   logic                    glyph_we;
   logic [GLYPH_AW-1:0]     glyph_ra;
   logic [7:0]              glyph_rd;
   logic                    bg_we;
   logic [15:0]             bg_rd;

   logic           s1_valid_ff;
   stage_meta_type s1_ff, s1_in;
   logic           s2_valid_ff;
   stage2_type     s2_ff, s2_in;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_ff, rsp_in;

   logic [7:0]  glyph;
   logic [7:0]  sel_byte;
   logic [1:0]  pair_bits;
   logic [31:0] words [4];

   // clearing sweep after reset
   assign clearing = state_ff == ST_CLEAR;
   assign clr_cell = clearing && (int'(clr_cnt_ff) < CELL_COUNT);
   assign clr_icon = clearing && (int'(clr_cnt_ff) < ICON_BANK_DEPTH);

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CLR_W'(CLR_COUNT - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign pop    = head_valid && (state_ff == ST_RUN);
   assign render = pop && (head.kind == KIND_RENDER);

   // character grid
   assign cell_we = clr_cell || (pop && (head.kind == KIND_CELL));
   assign cell_wa = clr_cell ? CELL_AW'(clr_cnt_ff) : head.cell_idx;
   assign cell_wd = clr_cell ? CELL_RESET_BYTE : head.wdata[7:0];

   tmlr_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_cells (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (cell_wa),
      .wr_data (cell_wd),
      .rd_addr (head.cell_idx),
      .rd_data (cell_rd)
   );

   // icon bitmap split into even and odd bytes so two neighbors read at once
   assign icon_wd = clr_icon ? ICON_RESET_BYTE : head.wdata[7:0];
   assign even_we = clr_icon ||
                    (pop && (head.kind == KIND_ICON) && !head.widx[0]);
   assign odd_we  = clr_icon ||
                    (pop && (head.kind == KIND_ICON) && head.widx[0]);
   assign even_wa = clr_icon ? ICON_BANK_AW'(clr_cnt_ff) : head.widx[ICON_AW-1:1];
   assign odd_wa  = even_wa;
   assign even_ra = head.icon_b0[ICON_AW-1:1] + ICON_BANK_AW'(head.icon_b0[0]);
   assign odd_ra  = head.icon_b0[ICON_AW-1:1];

   tmlr_ram #(.WIDTH(8), .DEPTH(ICON_BANK_DEPTH)) u_icon_even (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wa),
      .wr_data (icon_wd),
      .rd_addr (even_ra),
      .rd_data (even_rd)
   );

   tmlr_ram #(.WIDTH(8), .DEPTH(ICON_BANK_DEPTH)) u_icon_odd (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wa),
      .wr_data (icon_wd),
      .rd_addr (odd_ra),
      .rd_data (odd_rd)
   );

   // line colours
   assign bg_we = pop && (head.kind == KIND_COLOUR);

   tmlr_ram #(.WIDTH(16), .DEPTH(BG_DEPTH)) u_colours (
      .clock   (clock),
      .wr_en   (bg_we),
      .wr_addr (head.widx[BG_AW-1:0]),
      .wr_data (head.wdata),
      .rd_addr (head.colour_idx),
      .rd_data (bg_rd)
   );

   // glyph rows, addressed by the character fetched one stage earlier
   assign glyph_we = pop && (head.kind == KIND_GLYPH);
   assign glyph_ra = GLYPH_AW'(int'(cell_rd) * GLYPH_HEIGHT + int'(s1_ff.glyph_line));

   tmlr_ram #(.WIDTH(8), .DEPTH(GLYPH_COUNT)) u_glyphs (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (head.widx[GLYPH_AW-1:0]),
      .wr_data (head.wdata[7:0]),
      .rd_addr (glyph_ra),
      .rd_data (glyph_rd)
   );

   always_comb begin
      s1_in.column     = head.column;
      s1_in.glyph_line = head.glyph_line;
      s1_in.row_ok     = head.row_ok;
      s1_in.first_odd  = head.icon_b0[0];
      s1_in.icon_word  = head.icon_word;
      s2_in.meta       = s1_ff;
      s2_in.colour     = bg_rd;
      s2_in.icon_even  = even_rd;
      s2_in.icon_odd   = odd_rd;
   end

   // pixel pairs: icon byte where the icon covers the word, else glyph bits
   always_comb begin
      glyph     = s2_ff.meta.row_ok ? glyph_rd : 8'h00;
      sel_byte  = 8'h00;
      pair_bits = 2'b00;
      for (int k = 0; k < 4; k++) begin
         if (s2_ff.meta.icon_word[k].on) begin
            sel_byte  = (s2_ff.meta.icon_word[k].hi ^ s2_ff.meta.first_odd) ?
                        s2_ff.icon_odd : s2_ff.icon_even;
            pair_bits = 2'(sel_byte >> {~s2_ff.meta.icon_word[k].pair, 1'b0});
         end else begin
            pair_bits = 2'(glyph >> (6 - 2 * k));
         end
         words[k] = pair_word(pair_bits, s2_ff.colour);
      end
      rsp_in.out_column = s2_ff.meta.column;
      rsp_in.word0      = words[0];
      rsp_in.word1      = words[1];
      rsp_in.word2      = words[2];
      rsp_in.word3      = words[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= render;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/tmlr_checker.sv]
// port-level checks of the text mode line renderer and their bind
`timescale 1ns / 1ps
`default_nettype none

module tmlr_port_checks import tmlr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire req_item_type      req_data,
   input wire logic              rsp_valid,
   input wire rsp_item_type      rsp_data,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pwrite,
   input wire logic [CSR_AW-1:0] paddr,
   input wire logic [31:0]       pwdata,
   input wire logic [31:0]       prdata,
   input wire logic              pready
);

   logic render_take;
   logic left_wr;
   logic left_rd;

   assign render_take = start && !busy && (req_data.req_type == KIND_RENDER) &&
                        (req_data.column < TEXT_COLS);
   assign left_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ICON_LEFT);
   assign left_rd = psel && !pwrite && (paddr[2] == REG_ICON_LEFT);

   // every in-range render gives a result with its column
   a_render_result: assert property (@(posedge clock) disable iff (reset)
      render_take |-> ##4 (rsp_valid && (rsp_data.out_column == $past(req_data.column, 4))))
      else $error("render transfer without matching result");

   // no result without an earlier render transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_data.req_type == KIND_RENDER), 4))
      else $error("result without render transfer");

   a_column_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_column < TEXT_COLS))
      else $error("result column out of range");

   // sweep after reset holds requests off
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("requests open right after reset");

   a_left_readback: assert property (@(posedge clock) disable iff (reset)
      left_wr |=> (!left_rd || (prdata == {22'h0, $past(pwdata[CFG_W-1:0])})))
      else $error("icon left readback mismatch");

endmodule

bind text_mode_line_renderer tmlr_port_checks u_checker (.*);

`default_nettype wire
